// ===== rtl/cpm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cpm_pkg;

  // Default column capacity of the peak store
  localparam int MAX_WIDTH_DEF = 1024;

  // Entries in the queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 4;

  // Register map: index = paddr[3:2]
  localparam int PADDR_W = 4;
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_WIDTH     = 2'd1;
  localparam logic [1:0] REG_HEIGHT    = 2'd2;

  localparam logic [7:0]  THRESHOLD_RST = 8'd15;
  localparam logic [10:0] WIDTH_RST     = 11'd640;
  localparam logic [15:0] HEIGHT_RST    = 16'd480;

  localparam logic MODE_ACCUM = 1'b0;
  localparam logic MODE_MARK  = 1'b1;

  localparam logic [7:0] MARK_ON  = 8'hFF;
  localparam logic [7:0] MARK_OFF = 8'h00;

  typedef struct packed {
    logic [7:0]  threshold;
    logic [10:0] width;
    logic [15:0] height;
  } cpm_cfg_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic [7:0] pixel;
    logic       mode;
    logic       row_zero;
    logic       frame_end;
  } cpm_item_t;

endpackage

`default_nettype wire

// ===== rtl/column_peak_marker_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                                  Direction  Notes
// cfg       psel penable pwrite paddr pwdata prdata  in/out     APB-style, pready tied high
// in        in_valid in_ready pixel mode             in         one pixel per transfer
// out       out_valid out_ready mark frame_end       out        mark pass only
//
// Sustained rate: one pixel per cycle while neither the clearing pass nor an output stall
// holds the flow; the peak store is a single-port-write RAM read ahead of its update, with a
// one-entry bypass for back-to-back items on one column. Input transfer to result runs through
// queue, RAM read, out reg. After reset a clearing pass zeroes the peak store, in_ready low.
// Output stalls fill the queue and then drop in_ready; accumulate pixels keep
// draining until a mark pixel waits behind the held result.

module column_peak_marker_core #(
  parameter int MAX_WIDTH = cpm_pkg::MAX_WIDTH_DEF,
  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // configuration
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [cpm_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  // pixel input
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [7:0]                  pixel,
  input  wire logic                        mode,
  // marks out
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [7:0]                       mark,
  output logic                             frame_end
);
  import cpm_pkg::*;

  localparam int ENTRY_W = COL_W + $bits(cpm_item_t);

  cpm_cfg_t         cfg;
  logic             cfg_wr;
  logic [1:0]       reg_idx;

  logic             busy;
  logic             push, pop, q_full, q_empty;
  logic [COL_W-1:0] push_col, head_col;
  cpm_item_t        push_item, head_item;
  logic [ENTRY_W-1:0] head_entry;

  // ---------------------------------------------------------------
  // Register file: written in the access phase, zero-wait.
  // ---------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold <= THRESHOLD_RST;
      cfg.width     <= WIDTH_RST;
      cfg.height    <= HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_THRESHOLD: cfg.threshold <= pwdata[7:0];
        REG_WIDTH:     cfg.width     <= pwdata[10:0];
        REG_HEIGHT:    cfg.height    <= pwdata[15:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_THRESHOLD: prdata = {24'd0, cfg.threshold};
      REG_WIDTH:     prdata = {21'd0, cfg.width};
      REG_HEIGHT:    prdata = {16'd0, cfg.height};
      default:       prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------
  // Front: raster position tracking and classification of each pixel.
  // ---------------------------------------------------------------
  cpm_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pixel     (pixel),
    .mode      (mode),
    .busy      (busy),
    .q_full    (q_full),
    .push      (push),
    .push_col  (push_col),
    .push_item (push_item)
  );

  // ---------------------------------------------------------------
  // Queue decoupling front from the RAM pipeline.
  // ---------------------------------------------------------------
  cpm_queue #(.DATA_W(ENTRY_W)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_col, push_item}),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (head_entry),
    .empty     (q_empty)
  );

  assign head_col  = head_entry[ENTRY_W-1 -: COL_W];
  assign head_item = head_entry[$bits(cpm_item_t)-1:0];

  // ---------------------------------------------------------------
  // Back: column maxima store, update in accumulate pass, compare in
  // mark pass, result register towards the sink.
  // ---------------------------------------------------------------
  cpm_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .threshold (cfg.threshold),
    .q_empty   (q_empty),
    .head_col  (head_col),
    .head_item (head_item),
    .pop       (pop),
    .busy      (busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .mark      (mark),
    .frame_end (frame_end)
  );

endmodule

`default_nettype wire

// ===== rtl/cpm_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cpm_front #(
  parameter int MAX_WIDTH = cpm_pkg::MAX_WIDTH_DEF,
  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cpm_pkg::cpm_cfg_t cfg,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        pixel,
  input  wire logic              mode,
  input  wire logic              busy,
  input  wire logic              q_full,
  output logic                   push,
  output logic [COL_W-1:0]       push_col,
  output cpm_pkg::cpm_item_t     push_item
);
  import cpm_pkg::*;

  localparam logic [16:0] MAX_W17 = 17'(MAX_WIDTH);

  logic [COL_W-1:0] col, col_next;
  logic [15:0]      row, row_next;
  logic [16:0]      width_in, width_clamp;
  logic [COL_W-1:0] width_last, col_eff;
  logic [15:0]      height_last, row_eff;
  logic             last_col, last_row;

  always_comb begin
    width_in    = {6'd0, cfg.width};
    if (width_in == 17'd0) begin
      width_clamp = 17'd1;
    end else if (width_in > MAX_W17) begin
      width_clamp = MAX_W17;
    end else begin
      width_clamp = width_in;
    end
    width_last  = COL_W'(width_clamp - 17'd1);
    height_last = (cfg.height == 16'd0) ? 16'd0 : cfg.height - 16'd1;

    // position past a reduced size folds onto the last column / row
    col_eff  = (col > width_last) ? width_last : col;
    row_eff  = (row > height_last) ? height_last : row;
    last_col = (col_eff == width_last);
    last_row = (row_eff == height_last);

    if (last_col) begin
      col_next = '0;
      row_next = last_row ? 16'd0 : row_eff + 16'd1;
    end else begin
      col_next = col_eff + COL_W'(1);
      row_next = row_eff;
    end

    in_ready            = !busy && !q_full;
    push                = in_valid && in_ready;
    push_col            = col_eff;
    push_item.pixel     = pixel;
    push_item.mode      = mode;
    push_item.row_zero  = (row_eff == 16'd0);
    push_item.frame_end = last_col && last_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (push) begin
      col <= col_next;
      row <= row_next;
    end
  end

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (push && push_item.frame_end) |=> (col == '0 && row == 16'd0))
    else $error("position did not wrap after frame end");

endmodule

`default_nettype wire

// ===== rtl/cpm_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cpm_queue #(
  parameter int DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] push_data,
  output logic                   full,
  input  wire logic              pop,
  output logic [DATA_W-1:0]      pop_data,
  output logic                   empty
);
  import cpm_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  logic [DATA_W-1:0] entry [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [PTR_W:0]    count;

  assign full     = (count == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + (PTR_W+1)'(1);
        2'b01:   count <= count - (PTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    !(push && full) && !(pop && empty))
    else $error("queue overrun or underrun");

endmodule

`default_nettype wire

// ===== rtl/cpm_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cpm_back #(
  parameter int MAX_WIDTH = cpm_pkg::MAX_WIDTH_DEF,
  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [7:0]         threshold,
  input  wire logic               q_empty,
  input  wire logic [COL_W-1:0]   head_col,
  input  wire cpm_pkg::cpm_item_t head_item,
  output logic                    pop,
  output logic                    busy,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              mark,
  output logic                    frame_end
);
  import cpm_pkg::*;

  localparam logic [COL_W-1:0] CLEAR_LAST = COL_W'(MAX_WIDTH - 1);

  logic [7:0]       peak_mem [MAX_WIDTH];
  logic [7:0]       rdata;

  logic             clearing;
  logic [COL_W-1:0] clear_addr;

  logic             s2_valid;
  logic [COL_W-1:0] s2_col;
  cpm_item_t        s2_item;
  logic             fwd_hit;
  logic [7:0]       fwd_data;

  logic [7:0]       peak, peak_new;
  logic             s2_adv, s2_mark;
  logic             wr_en;
  logic [COL_W-1:0] wr_addr;
  logic [7:0]       wr_data;

  always_comb begin
    // write issued at the edge this item was read is not yet in rdata
    peak     = fwd_hit ? fwd_data : rdata;
    peak_new = (s2_item.row_zero || (s2_item.pixel > peak)) ? s2_item.pixel : peak;
    s2_mark  = (s2_item.mode == MODE_MARK);
    s2_adv   = s2_valid && (!s2_mark || !out_valid || out_ready);
    pop      = !q_empty && !clearing && (!s2_valid || s2_adv);
    busy     = clearing;
    wr_en    = clearing || (s2_adv && !s2_mark);
    wr_addr  = clearing ? clear_addr : s2_col;
    wr_data  = clearing ? 8'd0 : peak_new;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      peak_mem[wr_addr] <= wr_data;
    end
    if (pop) begin
      rdata <= peak_mem[head_col];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
      s2_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (clearing) begin
        clear_addr <= clear_addr + COL_W'(1);
        if (clear_addr == CLEAR_LAST) begin
          clearing <= 1'b0;
        end
      end
      if (pop) begin
        s2_valid <= 1'b1;
      end else if (s2_adv) begin
        s2_valid <= 1'b0;
      end
      if (s2_adv && s2_mark) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s2_col   <= head_col;
      s2_item  <= head_item;
      fwd_hit  <= wr_en && (s2_col == head_col);
      fwd_data <= peak_new;
    end
    if (s2_adv && s2_mark) begin
      mark      <= ((s2_item.pixel == peak) && (s2_item.pixel >= threshold))
                   ? MARK_ON : MARK_OFF;
      frame_end <= s2_item.frame_end;
    end
  end

  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!s2_valid && !pop))
    else $error("item in flight during clearing pass");

  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !s2_adv) |=> (s2_valid && $stable(s2_col) && $stable(s2_item)))
    else $error("stalled item lost or changed");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import cpm_pkg::*;

  localparam int          MAXW        = MAX_WIDTH_DEF;
  localparam int unsigned TARGET_ITEMS = 1150;
  // cycles allowed for accumulate pixels still inside the core once the
  // last mark has come out (queue, RAM read and peak-store write, with margin)
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned LONG_HOLD    = 250;
  // covers the clearing pass after reset, the long output hold and the
  // longest sender gap several times over
  localparam int unsigned QUIET_LIMIT  = 5000;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    logic [7:0] px;
    logic       md;
  } pixel_item_t;

  typedef struct packed {
    logic [7:0] mark;
    logic       frame_end;
  } mark_result_t;

  // ---------------------------------------------------------------- DUT I/O
  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 psel      = 1'b0;
  logic                 penable   = 1'b0;
  logic                 pwrite    = 1'b0;
  logic [PADDR_W-1:0]   paddr     = '0;
  logic [31:0]          pwdata    = '0;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [7:0]           pixel     = '0;
  logic                 mode      = MODE_ACCUM;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [7:0]           mark;
  logic                 frame_end;

  column_peak_marker_core #(.MAX_WIDTH(MAXW)) DUT (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pixel     (pixel),
    .mode      (mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .mark      (mark),
    .frame_end (frame_end)
  );

  always #6 clk = ~clk;

  // ------------------------------------------------------- shared TB state
  pixel_item_t  pending_pixels[$];   // filled by the stimulus, drained by the driver
  mark_result_t marks_due[$];        // predicted marks, oldest first
  int unsigned  items_sent   = 0;
  int unsigned  items_taken  = 0;
  int unsigned  results_seen = 0;
  int unsigned  errors       = 0;
  bit           tx_idle_on   = 1'b0;
  bit           rx_idle_on   = 1'b0;
  int unsigned  stall_token  = 0;    // bumped to request one long output hold

  // Predictor copy of the core: register values, column maxima, position.
  logic [7:0]   cfg_thr    = THRESHOLD_RST;
  logic [10:0]  cfg_width  = WIDTH_RST;
  logic [15:0]  cfg_height = HEIGHT_RST;
  logic [7:0]   peak_model[MAXW];
  int unsigned  pos_col    = 0;
  int unsigned  pos_row    = 0;

  // width 0 behaves as 1, anything past the store behaves as the full store
  function automatic int unsigned eff_width();
    if (cfg_width == 0) return 1;
    if (cfg_width > MAXW) return MAXW;
    return cfg_width;
  endfunction

  function automatic int unsigned eff_height();
    return (cfg_height == 0) ? 1 : cfg_height;
  endfunction

  // Works out what one accepted pixel does: updates the column maximum in the
  // accumulate pass, or queues the mark it must give in the mark pass.
  function automatic void predict_mark(input logic [7:0] px, input logic md);
    int unsigned  w, h, c, r;
    bit           last_c, last_r;
    mark_result_t res;
    w = eff_width();
    h = eff_height();
    c = pos_col;
    r = pos_row;
    // a position left over from a larger geometry lands on the last column/row
    if (c >= w) c = w - 1;
    if (r >= h) r = h - 1;
    last_c = (c == w - 1);
    last_r = (r == h - 1);
    if (md == MODE_ACCUM) begin
      // row 0 restarts the maximum, later rows only raise it
      if (r == 0 || px > peak_model[c]) peak_model[c] = px;
    end else begin
      res.mark      = (px == peak_model[c] && px >= cfg_thr) ? MARK_ON : MARK_OFF;
      res.frame_end = last_c && last_r;
      marks_due.push_back(res);
    end
    if (last_c) begin
      pos_col = 0;
      pos_row = last_r ? 0 : ((r + 1) & 16'hFFFF);
    end else begin
      pos_col = c + 1;
      pos_row = r;
    end
  endfunction

  // Mostly back to back, a fair share of short gaps, the odd long one.
  function automatic int unsigned pick_gap(input bit enabled);
    int unsigned roll;
    if (!enabled) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void flag_error(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // ---------------------------------------------------------------- driver
  // Offers pending pixels; payload and valid only move once the current
  // transfer has completed. Prediction happens at the accepting edge.
  pixel_item_t next_item;
  int unsigned tx_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_mark(pixel, mode);
        items_taken++;
      end
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (pending_pixels.size() != 0) begin
          next_item = pending_pixels.pop_front();
          pixel    <= next_item.px;
          mode     <= next_item.md;
          in_valid <= 1'b1;
          tx_gap    = pick_gap(tx_idle_on);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------- monitor
  // Checks each mark transfer against the oldest prediction and drives
  // out_ready, including the long hold that backs the core up.
  mark_result_t due_mark;
  int unsigned  rx_gap     = 0;
  int unsigned  hold_left  = 0;
  int unsigned  stall_seen = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (marks_due.size() == 0) begin
          flag_error($sformatf("unexpected mark %0d frame_end %0b", mark, frame_end));
        end else begin
          due_mark = marks_due.pop_front();
          if (mark !== due_mark.mark || frame_end !== due_mark.frame_end)
            flag_error($sformatf("mark #%0d: want %0d/%0b, got %0d/%0b", results_seen,
                                 due_mark.mark, due_mark.frame_end, mark, frame_end));
        end
        results_seen++;
      end
      if (stall_token != stall_seen) begin
        stall_seen = stall_token;
        hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        rx_gap     = pick_gap(rx_idle_on);
      end
    end
  end

  // -------------------------------------------------------------- watchdog
  // Any transfer on either stream or a register write counts as progress.
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pwrite && pready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ------------------------------------------------------ stimulus helpers
  function automatic void send_pixel(input logic [7:0] px, input logic md);
    pixel_item_t it;
    it.px = px;
    it.md = md;
    pending_pixels.push_back(it);
    items_sent++;
  endfunction

  // Holds the sender until every pixel is taken and every mark has come out,
  // then lets trailing accumulate pixels clear the pipeline.
  task automatic wait_idle();
    while (items_taken != items_sent || marks_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Setup cycle then access cycle; the register takes the value at the
  // edge where the access completes.
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_THRESHOLD: cfg_thr    = val[7:0];
      REG_WIDTH:     cfg_width  = val[10:0];
      REG_HEIGHT:    cfg_height = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(input logic [7:0] thr, input logic [10:0] w,
                              input logic [15:0] h);
    wait_idle();
    reg_write(REG_THRESHOLD, {24'd0, thr});
    reg_write(REG_WIDTH, {21'd0, w});
    reg_write(REG_HEIGHT, {16'd0, h});
  endtask

  // -------------------------------------------------------------- stimulus
  initial begin
    int unsigned phase_no, w, h, c, r, n, frames, roll;
    logic [7:0]  thr, px;
    bit          well_formed, pressure;
    logic [7:0]  img[$];

    foreach (peak_model[i]) peak_model[i] = 8'd0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // --- directed ---------------------------------------------------------
    // 3x2 frame: column 0 peaks on row 0, column 1 is flat zero (below
    // threshold), column 2 peaks on row 0 while row 1 sits just below threshold
    set_geometry(8'd15, 11'd3, 16'd2);
    send_pixel(8'd255, MODE_ACCUM); send_pixel(8'd0, MODE_ACCUM); send_pixel(8'd20, MODE_ACCUM);
    send_pixel(8'd100, MODE_ACCUM); send_pixel(8'd0, MODE_ACCUM); send_pixel(8'd14, MODE_ACCUM);
    send_pixel(8'd255, MODE_MARK);  send_pixel(8'd0, MODE_MARK);  send_pixel(8'd20, MODE_MARK);
    send_pixel(8'd100, MODE_MARK);  send_pixel(8'd0, MODE_MARK);  send_pixel(8'd14, MODE_MARK);

    // 1x1 frames, threshold zero: row 0 must overwrite a larger old maximum
    set_geometry(8'd0, 11'd1, 16'd1);
    send_pixel(8'd7, MODE_ACCUM); send_pixel(8'd7, MODE_MARK);
    send_pixel(8'd3, MODE_ACCUM); send_pixel(8'd3, MODE_MARK);

    // zero width and height behave as 1x1; threshold at the top of its range
    set_geometry(8'd255, 11'd0, 16'd0);
    send_pixel(8'd255, MODE_ACCUM); send_pixel(8'd255, MODE_MARK); send_pixel(8'd254, MODE_MARK);

    // oversized width clamps to the store; modes mixed inside one row
    set_geometry(8'd128, 11'd2047, 16'd65535);
    send_pixel(8'd255, MODE_MARK); send_pixel(8'd200, MODE_ACCUM); send_pixel(8'd200, MODE_MARK);

    // width cut below the current column: pixel lands on the last column
    set_geometry(8'd128, 11'd1, 16'd65535);
    send_pixel(8'd255, MODE_MARK); send_pixel(8'd4, MODE_ACCUM);

    // height cut below the current row: treated as the last row, frame ends
    set_geometry(8'd128, 11'd2, 16'd2);
    send_pixel(8'd255, MODE_MARK); send_pixel(8'd200, MODE_MARK);

    // --- random phases ----------------------------------------------------
    phase_no = 0;
    while (items_sent < TARGET_ITEMS) begin
      phase_no++;
      pressure    = (phase_no % 12 == 1);
      well_formed = pressure || ($urandom_range(0, 3) != 0);
      if (pressure) begin
        w = 8;
        h = 5;
      end else if (well_formed) begin
        // wide frames only while plenty of the item budget is left
        if (TARGET_ITEMS - items_sent > 600 && $urandom_range(0, 7) == 0) begin
          w = $urandom_range(9, 48);
          h = $urandom_range(1, 3);
        end else begin
          w = $urandom_range(1, 8);
          h = $urandom_range(1, 5);
        end
      end else begin
        w = $urandom_range(0, 1) ? $urandom_range(0, 6) : $urandom_range(0, 2047);
        h = $urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom_range(0, 65535);
      end
      roll = $urandom_range(0, 5);
      thr  = (roll == 0) ? 8'd0 : (roll == 1) ? 8'd255 : 8'($urandom_range(0, 255));
      set_geometry(thr, 11'(w), 16'(h));

      // the sender runs flat out under pressure so the core is sure to fill
      tx_idle_on = !pressure && ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      // output held off while a full frame pours in: the core must back up
      if (pressure) stall_token++;

      if (well_formed) begin
        // finish whatever frame the core is part way through
        c = pos_col;
        r = pos_row;
        if (c >= eff_width()) c = eff_width() - 1;
        if (r >= eff_height()) r = eff_height() - 1;
        if (c != 0 || r != 0) begin
          n = (eff_height() - 1 - r) * eff_width() + (eff_width() - c);
          repeat (n) send_pixel(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
        frames = $urandom_range(1, 3);
        while (frames > 1 && items_sent + 2 * w * h * frames > TARGET_ITEMS) frames--;
        repeat (frames) begin
          // same image twice: maxima first, then marks
          img.delete();
          repeat (w * h) begin
            roll = $urandom_range(0, 9);
            case (roll)
              0:       px = 8'd0;
              1:       px = 8'hFF;
              2:       px = thr;
              3:       px = thr - 8'd1;
              4:       px = thr + 8'd1;
              default: px = 8'($urandom_range(0, 255));
            endcase
            img.push_back(px);
          end
          foreach (img[i]) send_pixel(img[i], MODE_ACCUM);
          // now and then the second pass differs from the first
          if ($urandom_range(0, 5) == 0)
            img[$urandom_range(0, w * h - 1)] = 8'($urandom_range(0, 255));
          foreach (img[i]) send_pixel(img[i], MODE_MARK);
        end
      end else begin
        repeat ($urandom_range(4, 40))
          send_pixel(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end

    // --- wind down ----------------------------------------------------------
    wait_idle();
    if (marks_due.size() != 0)
      flag_error($sformatf("%0d marks never came out", marks_due.size()));
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
